/* rtl/core/cpl_pkg.sv */
package cpl_pkg;

   localparam int MAX_PINS     = 8;
   localparam int MAX_LEDS_DEF = 56;
   localparam int PIN_W        = 4;
   localparam int CSR_IDX_W    = 4;
   localparam int CSR_DATA_W   = 16;

   localparam logic [1:0] ACT_TICK    = 2'd0;
   localparam logic [1:0] ACT_REFRESH = 2'd1;
   localparam logic [1:0] ACT_SET     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_PINS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME   = CSR_IDX_W'(1);

   localparam logic [3:0]  ACTIVE_PINS_RST = 4'd3;
   localparam logic [15:0] HOLD_TIME_RST   = 16'd833;
   localparam logic [15:0] TICKS_MAX       = 16'hFFFF;
   localparam logic [7:0]  PHASE_RST       = 8'hC0;
   localparam logic [7:0]  PHASE_STEP      = 8'h40;
   localparam logic [7:0]  LEVEL_FULL      = 8'hFF;

   typedef struct packed {
      logic [1:0] action;
      logic [5:0] led_index;
      logic [7:0] led_level;
   } req_type;

   typedef struct packed {
      logic [7:0] pin_output_mask;
      logic [7:0] pin_high_mask;
      logic       analog_active;
      logic [7:0] analog_duty;
      logic       lit_valid;
      logic [5:0] lit_index;
      logic       refreshed;
   } rsp_type;

   typedef struct packed {
      logic             done;
      logic [PIN_W-1:0] anode;
      logic [PIN_W-1:0] cathode;
   } pair_type;

   // pin positions past the eighth do not show in the masks
   function automatic logic [7:0] pin_bit(input logic [PIN_W-1:0] pos);
      logic [7:0] b;
      b = '0;
      if (pos < PIN_W'(8)) b = 8'(1) << pos;
      return b;
   endfunction

endpackage

/* rtl/core/cpl_level_mem.sv */
module cpl_level_mem import cpl_pkg::*; #(
   parameter int DEPTH = MAX_LEDS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0]       mem_ff [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [7:0]       rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= vld_ff[rd_addr] ? mem_ff[rd_addr] : 8'd0;
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/cpl_pair_walk.sv */
module cpl_pair_walk import cpl_pkg::*; #(
   parameter int AW = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    target,
   input  logic [PIN_W-1:0] pins,
   output pair_type         pair
);

   logic             busy_ff, busy_in;
   logic [AW-1:0]    tgt_ff, tgt_in;
   logic [AW-1:0]    n_ff, n_in;
   logic [PIN_W-1:0] pass_ff, pass_in;
   logic [PIN_W-1:0] pin_ff, pin_in;
   logic             dir_ff, dir_in;
   logic             hit;
   logic [PIN_W:0]   reach;

   // one LED number per cycle: forward pair, then reverse pair, then next pin
   always_comb begin
      hit     = busy_ff && (n_ff == tgt_ff);
      reach   = {1'b0, pin_ff} + {1'b0, pass_ff} + (PIN_W+1)'(1);
      busy_in = busy_ff;
      tgt_in  = tgt_ff;
      n_in    = n_ff;
      pass_in = pass_ff;
      pin_in  = pin_ff;
      dir_in  = dir_ff;
      if (start) begin
         busy_in = 1'b1;
         tgt_in  = target;
         n_in    = '0;
         pass_in = PIN_W'(1);
         pin_in  = '0;
         dir_in  = 1'b0;
      end else if (hit) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         n_in = n_ff + AW'(1);
         if (!dir_ff) begin
            dir_in = 1'b1;
         end else begin
            dir_in = 1'b0;
            if (reach >= {1'b0, pins}) begin
               pass_in = pass_ff + PIN_W'(1);
               pin_in  = '0;
            end else begin
               pin_in = pin_ff + PIN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff  <= tgt_in;
      n_ff    <= n_in;
      pass_ff <= pass_in;
      pin_ff  <= pin_in;
      dir_ff  <= dir_in;
   end

   assign pair.done    = hit;
   assign pair.anode   = dir_ff ? pin_ff + pass_ff : pin_ff;
   assign pair.cathode = dir_ff ? pin_ff : pin_ff + pass_ff;

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> n_ff <= tgt_ff)
      else $error("pair walk passed its target");

   a_pair_distinct: assert property (@(posedge clock) disable iff (reset)
      pair.done |-> pair.anode != pair.cathode)
      else $error("anode equals cathode");

endmodule

/* rtl/core/charlieplex_led_scanner.sv */
// channel  dir  handshake                payload
// req      in   req_valid / req_stall    req_data  (req_type)
// rsp      out  rsp_valid / rsp_stall    rsp_data  (rsp_type)
// csr      in   csr_valid / csr_ready    csr_index, csr_data
//
// One beat in, one beat out. Tick without refresh, set and no-op go from idle to the
// final state, then into the output register. Refresh reads up to count entries
// of the level memory, steps the pair walker to the first lit index found, then
// registers the result; with nothing lit the scan ends in the final state.
// Reset clears the level memory at once through per-entry valid bits; no clearing pass.
// A result held by rsp_stall sits in the output register; the next beat is
// still taken and its result waits in the final state until the register frees.
module charlieplex_led_scanner import cpl_pkg::*; #(
   parameter int MAX_LEDS = MAX_LEDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW = $clog2(MAX_LEDS);
   localparam int CW = $clog2(MAX_LEDS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_WALK = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  act_pins_ff, act_pins_in;
   logic [15:0] hold_ff, hold_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic        cur_valid_ff, cur_valid_in;
   logic [AW-1:0] cur_led_ff, cur_led_in;
   logic [7:0]  phase_ff, phase_in;
   logic [7:0]  den_ff, den_in;
   logic [7:0]  dlv_ff, dlv_in;
   logic [8:0]  ana_ff, ana_in;
   logic        refreshed_ff, refreshed_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] left_ff, left_in;
   logic        chk_ff, chk_in;
   logic [AW-1:0] chk_idx_ff, chk_idx_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic [7:0]  level_ff, level_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [PIN_W-1:0]   pins;
   logic [2*PIN_W-1:0] prod;
   logic [CW-1:0]      count;
   logic [CW-1:0]      start_pos;
   logic [CW-1:0]      next_pos;
   logic [CW+5:0]      set_idx_ext;
   logic [CW+5:0]      count_ext;
   logic [15:0]        ticks_inc;
   logic               req_accept;
   logic               csr_write;
   logic               same;
   logic [7:0]         phase_next;
   logic [7:0]         an_bit;
   logic [7:0]         ca_bit;

   logic               mem_wr;
   logic               mem_rd;
   logic [7:0]         mem_rdata;
   logic               walk_start;
   pair_type           pair;

   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   // pins clamped to [2, MAX_PINS], LED count clamped to memory depth
   always_comb begin
      if (act_pins_ff < 4'd2) pins = PIN_W'(2);
      else if (int'(act_pins_ff) > MAX_PINS) pins = PIN_W'(MAX_PINS);
      else pins = PIN_W'(act_pins_ff);
      prod  = (2*PIN_W)'(pins) * (2*PIN_W)'(pins - PIN_W'(1));
      count = (int'(prod) > MAX_LEDS) ? CW'(MAX_LEDS) : CW'(prod);
   end

   always_comb begin
      start_pos = cur_valid_ff ? CW'(cur_led_ff) + CW'(1) : '0;
      if (start_pos >= count) start_pos = '0;
      next_pos = CW'(idx_ff) + CW'(1);
      if (next_pos >= count) next_pos = '0;
      set_idx_ext = (CW+6)'(req_data.led_index);
      count_ext   = (CW+6)'(count);
      ticks_inc   = (elapsed_ff == TICKS_MAX) ? elapsed_ff : elapsed_ff + 16'd1;
      same        = cur_valid_ff && (cur_led_ff == hit_idx_ff);
      phase_next  = phase_ff + PHASE_STEP;
      an_bit      = pin_bit(pair.anode);
      ca_bit      = pin_bit(pair.cathode);
   end

   always_comb begin
      act_pins_in = act_pins_ff;
      hold_in     = hold_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ACTIVE_PINS: act_pins_in = csr_data[3:0];
            CSR_HOLD_TIME:   hold_in     = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      elapsed_in   = elapsed_ff;
      cur_valid_in = cur_valid_ff;
      cur_led_in   = cur_led_ff;
      phase_in     = phase_ff;
      den_in       = den_ff;
      dlv_in       = dlv_ff;
      ana_in       = ana_ff;
      refreshed_in = refreshed_ff;
      idx_in       = idx_ff;
      left_in      = left_ff;
      chk_in       = chk_ff;
      chk_idx_in   = chk_idx_ff;
      hit_idx_in   = hit_idx_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_wr       = 1'b0;
      mem_rd       = 1'b0;
      walk_start   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               refreshed_in = 1'b0;
               state_in     = ST_DONE;
               case (req_data.action)
                  ACT_TICK: begin
                     if (ticks_inc >= hold_ff) begin
                        elapsed_in   = '0;
                        refreshed_in = 1'b1;
                        state_in     = ST_SCAN;
                     end else begin
                        elapsed_in = ticks_inc;
                     end
                  end
                  ACT_REFRESH: begin
                     refreshed_in = 1'b1;
                     state_in     = ST_SCAN;
                  end
                  ACT_SET: begin
                     mem_wr = set_idx_ext < count_ext;
                  end
                  default: ;
               endcase
               if (state_in == ST_SCAN) begin
                  idx_in  = AW'(start_pos);
                  left_in = count;
                  chk_in  = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            // read one entry per cycle, check the previous read's data
            mem_rd     = left_ff != '0;
            chk_in     = mem_rd;
            chk_idx_in = idx_ff;
            if (mem_rd) begin
               left_in = left_ff - CW'(1);
               idx_in  = AW'(next_pos);
            end
            if (chk_ff && mem_rdata != 8'd0) begin
               level_in   = mem_rdata;
               hit_idx_in = chk_idx_ff;
               walk_start = 1'b1;
               chk_in     = 1'b0;
               state_in   = ST_WALK;
            end else if (!chk_ff && left_ff == '0) begin
               cur_valid_in = 1'b0;
               cur_led_in   = '0;
               den_in       = '0;
               dlv_in       = '0;
               ana_in       = '0;
               state_in     = ST_DONE;
            end
         end
         ST_WALK: begin
            if (pair.done) begin
               phase_in = phase_next;
               if (!same) begin
                  den_in = an_bit | ca_bit;
                  dlv_in = (level_ff > phase_next) ? an_bit : 8'd0;
                  ana_in = '0;
               end else if (level_ff == LEVEL_FULL) begin
                  dlv_in = dlv_ff | an_bit;
                  ana_in = '0;
               end else begin
                  dlv_in = dlv_ff & ~an_bit;
                  ana_in = {1'b1, level_ff};
               end
               cur_valid_in = 1'b1;
               cur_led_in   = hit_idx_ff;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_in) begin
               rsp_valid_in           = 1'b1;
               rsp_in.pin_output_mask = den_ff;
               rsp_in.pin_high_mask   = dlv_ff;
               rsp_in.analog_active   = ana_ff[8];
               rsp_in.analog_duty     = ana_ff[8] ? ana_ff[7:0] : 8'd0;
               rsp_in.lit_valid       = cur_valid_ff;
               rsp_in.lit_index       = cur_valid_ff ? 6'(cur_led_ff) : 6'd0;
               rsp_in.refreshed       = refreshed_ff;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         act_pins_ff  <= ACTIVE_PINS_RST;
         hold_ff      <= HOLD_TIME_RST;
         elapsed_ff   <= '0;
         cur_valid_ff <= 1'b0;
         cur_led_ff   <= '0;
         phase_ff     <= PHASE_RST;
         den_ff       <= '0;
         dlv_ff       <= '0;
         ana_ff       <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         act_pins_ff  <= act_pins_in;
         hold_ff      <= hold_in;
         elapsed_ff   <= elapsed_in;
         cur_valid_ff <= cur_valid_in;
         cur_led_ff   <= cur_led_in;
         phase_ff     <= phase_in;
         den_ff       <= den_in;
         dlv_ff       <= dlv_in;
         ana_ff       <= ana_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      refreshed_ff <= refreshed_in;
      idx_ff       <= idx_in;
      left_ff      <= left_in;
      chk_idx_ff   <= chk_idx_in;
      hit_idx_ff   <= hit_idx_in;
      level_ff     <= level_in;
      rsp_ff       <= rsp_in;
   end

   cpl_level_mem #(
      .DEPTH (MAX_LEDS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr),
      .wr_addr (AW'(req_data.led_index)),
      .wr_data (req_data.led_level),
      .rd_en   (mem_rd),
      .rd_addr (idx_ff),
      .rd_data (mem_rdata)
   );

   cpl_pair_walk #(
      .AW (AW)
   ) u_walk (
      .clock  (clock),
      .reset  (reset),
      .start  (walk_start),
      .target (chk_idx_ff),
      .pins   (pins),
      .pair   (pair)
   );

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> CW'(hit_idx_ff) < count)
      else $error("found LED beyond count");

   a_dark_masks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.lit_valid |->
         rsp_ff.pin_output_mask == 8'd0 && rsp_ff.pin_high_mask == 8'd0)
      else $error("pins driven with no LED lit");

   a_analog_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.analog_active |-> rsp_ff.lit_valid)
      else $error("analog duty with no LED lit");

   a_chk_scan_only: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_SCAN |-> !chk_ff)
      else $error("pending read check outside scan");

   a_walk_in_walk: assert property (@(posedge clock) disable iff (reset)
      pair.done |-> state_ff == ST_WALK)
      else $error("pair walk finished outside walk state");

endmodule
